[rtl/core/cau_pkg.sv]
// Shared types, constants and helper functions of the complex arithmetic unit.
package cau_pkg;

    localparam int DW = 16;            // word width of every operand and result part
    localparam int FB = 8;             // fraction bits
    localparam int PW = 2 * DW;        // product width
    localparam int SW = 2 * DW + 1;    // signed sum of two products
    localparam int MW = 2 * DW;        // magnitude of such a sum
    localparam int IT_STAGES = DW / 2; // two recurrence steps per stage
    localparam int UNIT_LAT = IT_STAGES + 1;
    localparam int LAT = UNIT_LAT + 3;
    localparam int OVF_SH = DW - FB;

    localparam logic [MW-1:0] MAG_MAX = MW'((64'd1 << (DW - 1)) - 64'd1);
    localparam logic [MW-1:0] MAG_MIN = MW'(64'd1 << (DW - 1));

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CONJ = 3'd4,
        OP_INV  = 3'd5,
        OP_MAG  = 3'd6,
        OP_EQ   = 3'd7
    } op_t;

    typedef logic signed [DW-1:0] word_t;

    typedef struct packed {
        logic  sat;
        word_t val;
    } sat_t;

    // per-item info that rides beside the divider and root pipelines
    typedef struct packed {
        op_t   op;
        word_t re;
        word_t im;
        logic  sat;
        logic  eq;
        logic  dz;
        logic  re_neg;
        logic  im_neg;
    } side_t;

    function automatic logic [MW-1:0] mag_of(input logic signed [SW-1:0] v);
        logic [SW-1:0] u;
        u = v[SW-1] ? SW'(-v) : SW'(v);
        return u[MW-1:0];
    endfunction

    function automatic sat_t sat_mag(input logic neg, input logic [MW-1:0] mag);
        sat_t r;
        r.sat = 1'b0;
        if (!neg)
        begin
            if (mag > MAG_MAX)
            begin
                r.sat = 1'b1;
                r.val = word_t'(MAG_MAX[DW-1:0]);
            end
            else
            begin
                r.val = word_t'(mag[DW-1:0]);
            end
        end
        else
        begin
            if (mag > MAG_MIN)
            begin
                r.sat = 1'b1;
                r.val = word_t'(MAG_MIN[DW-1:0]);
            end
            else
            begin
                r.val = word_t'(DW'(0) - mag[DW-1:0]);
            end
        end
        return r;
    endfunction

endpackage

[rtl/core/cau_front.sv]
// Front end: products and simple ops, then sums, numerators and denominator.
module cau_front (
    input  logic                    clk,
    input  logic                    adv,
    input  cau_pkg::op_t            op,
    input  cau_pkg::word_t          a_re,
    input  cau_pkg::word_t          a_im,
    input  cau_pkg::word_t          b_re,
    input  cau_pkg::word_t          b_im,
    output cau_pkg::side_t          side,
    output logic [cau_pkg::MW-1:0]  num_re,
    output logic [cau_pkg::MW-1:0]  num_im,
    output logic [cau_pkg::MW-1:0]  den
);
    import cau_pkg::*;

    // stage 1
    op_t                  op_reg;
    word_t                ar_reg, ai_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, sq_r_reg, sq_i_reg;
    word_t                s_re_reg, s_im_reg;
    logic                 s_sat_reg, s_eq_reg;

    word_t                sel_re, sel_im;
    logic signed [DW:0]   t_re, t_im;
    sat_t                 st_re, st_im;

    always_comb
    begin
        sel_re = (op == OP_INV || op == OP_MAG) ? a_re : b_re;
        sel_im = (op == OP_INV || op == OP_MAG) ? a_im : b_im;
        t_re = '0;
        t_im = '0;
        unique case (op)
            OP_ADD:
            begin
                t_re = (DW+1)'(a_re) + (DW+1)'(b_re);
                t_im = (DW+1)'(a_im) + (DW+1)'(b_im);
            end
            OP_SUB:
            begin
                t_re = (DW+1)'(a_re) - (DW+1)'(b_re);
                t_im = (DW+1)'(a_im) - (DW+1)'(b_im);
            end
            OP_CONJ:
            begin
                t_re = (DW+1)'(a_re);
                t_im = -(DW+1)'(a_im);
            end
            default:
            begin
                t_re = '0;
                t_im = '0;
            end
        endcase
        st_re = sat_mag(t_re[DW], mag_of(SW'(t_re)));
        st_im = sat_mag(t_im[DW], mag_of(SW'(t_im)));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_reg    <= op;
            ar_reg    <= a_re;
            ai_reg    <= a_im;
            p_rr_reg  <= a_re * b_re;
            p_ii_reg  <= a_im * b_im;
            p_ri_reg  <= a_re * b_im;
            p_ir_reg  <= a_im * b_re;
            sq_r_reg  <= sel_re * sel_re;
            sq_i_reg  <= sel_im * sel_im;
            s_re_reg  <= st_re.val;
            s_im_reg  <= st_im.val;
            s_sat_reg <= st_re.sat | st_im.sat;
            s_eq_reg  <= (op == OP_EQ) && (a_re == b_re) && (a_im == b_im);
        end
    end

    // stage 2
    logic signed [SW-1:0] mul_re, mul_im, dv_re, dv_im;
    logic [MW-1:0]        den_c;
    sat_t                 m_re, m_im;
    side_t                side_next, side_reg;
    logic [MW-1:0]        num_re_next, num_im_next;
    logic [MW-1:0]        num_re_reg, num_im_reg, den_reg;

    always_comb
    begin
        mul_re = SW'(p_rr_reg) - SW'(p_ii_reg);
        mul_im = SW'(p_ri_reg) + SW'(p_ir_reg);
        dv_re  = SW'(p_rr_reg) + SW'(p_ii_reg);
        dv_im  = SW'(p_ir_reg) - SW'(p_ri_reg);
        den_c  = $unsigned(sq_r_reg) + $unsigned(sq_i_reg);
        m_re   = sat_mag(mul_re[SW-1], mag_of(mul_re) >> FB);
        m_im   = sat_mag(mul_im[SW-1], mag_of(mul_im) >> FB);

        side_next.op  = op_reg;
        side_next.eq  = s_eq_reg;
        side_next.dz  = (op_reg == OP_DIV || op_reg == OP_INV) && (den_c == '0);
        if (op_reg == OP_MUL)
        begin
            side_next.re  = m_re.val;
            side_next.im  = m_im.val;
            side_next.sat = m_re.sat | m_im.sat;
        end
        else
        begin
            side_next.re  = s_re_reg;
            side_next.im  = s_im_reg;
            side_next.sat = s_sat_reg;
        end
        // 1/A uses numerator 2^FB + 0j, so the cross terms reduce to shifts
        if (op_reg == OP_INV)
        begin
            side_next.re_neg = ar_reg[DW-1];
            side_next.im_neg = ~ai_reg[DW-1];
            num_re_next = mag_of(SW'(ar_reg)) << FB;
            num_im_next = mag_of(SW'(ai_reg)) << FB;
        end
        else
        begin
            side_next.re_neg = dv_re[SW-1];
            side_next.im_neg = dv_im[SW-1];
            num_re_next = mag_of(dv_re);
            num_im_next = mag_of(dv_im);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg   <= side_next;
            num_re_reg <= num_re_next;
            num_im_reg <= num_im_next;
            den_reg    <= den_c;
        end
    end

    assign side   = side_reg;
    assign num_re = num_re_reg;
    assign num_im = num_im_reg;
    assign den    = den_reg;

endmodule

[rtl/core/cau_div.sv]
// Pipelined restoring divider, two lanes sharing one denominator.
module cau_div (
    input  logic                    clk,
    input  logic                    adv,
    input  logic [cau_pkg::MW-1:0]  num_re,
    input  logic [cau_pkg::MW-1:0]  num_im,
    input  logic [cau_pkg::MW-1:0]  den,
    output logic [cau_pkg::MW-1:0]  q_re,
    output logic [cau_pkg::MW-1:0]  q_im
);
    import cau_pkg::*;

    typedef struct packed {
        logic [MW-1:0] rem;
        logic [DW-1:0] feed;
        logic [DW-1:0] q;
        logic          ovf;
    } lane_t;

    function automatic lane_t div_step(input lane_t l, input logic [MW-1:0] d);
        lane_t         r;
        logic [MW:0]   r2;
        r = l;
        r2 = {l.rem, l.feed[DW-1]};
        r.feed = l.feed << 1;
        if (r2 >= {1'b0, d})
        begin
            r2 = r2 - {1'b0, d};
            r.q = {l.q[DW-2:0], 1'b1};
        end
        else
        begin
            r.q = {l.q[DW-2:0], 1'b0};
        end
        r.rem = r2[MW-1:0];
        return r;
    endfunction

    function automatic lane_t div_load(input logic [MW-1:0] m, input logic [MW-1:0] d);
        lane_t r;
        // quotient needs more than DW bits: flagged and clipped later
        r.ovf  = {m, OVF_SH'(0)} >= {OVF_SH'(0), d, OVF_SH'(0)} >> 0
                 ? ({OVF_SH'(0), m} >= {d, OVF_SH'(0)}) : 1'b0;
        r.rem  = m >> OVF_SH;
        r.feed = {m[OVF_SH-1:0], FB'(0)};
        r.q    = '0;
        return r;
    endfunction

    lane_t         re_reg [0:IT_STAGES];
    lane_t         im_reg [0:IT_STAGES];
    logic [MW-1:0] den_reg [0:IT_STAGES];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            re_reg[0]  <= div_load(num_re, den);
            im_reg[0]  <= div_load(num_im, den);
            den_reg[0] <= den;
        end
    end

    for (genvar k = 1; k <= IT_STAGES; k++)
    begin : g_stage
        lane_t re_next, im_next;
        always_comb
        begin
            re_next = div_step(div_step(re_reg[k-1], den_reg[k-1]), den_reg[k-1]);
            im_next = div_step(div_step(im_reg[k-1], den_reg[k-1]), den_reg[k-1]);
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                re_reg[k]  <= re_next;
                im_reg[k]  <= im_next;
                den_reg[k] <= den_reg[k-1];
            end
        end
    end

    assign q_re = re_reg[IT_STAGES].ovf ? MAG_MIN + MW'(1) : MW'(re_reg[IT_STAGES].q);
    assign q_im = im_reg[IT_STAGES].ovf ? MAG_MIN + MW'(1) : MW'(im_reg[IT_STAGES].q);

endmodule

[rtl/core/cau_sqrt.sv]
// Pipelined digit-by-digit integer square root.
module cau_sqrt (
    input  logic                    clk,
    input  logic                    adv,
    input  logic [cau_pkg::MW-1:0]  rad,
    output logic [cau_pkg::MW-1:0]  root
);
    import cau_pkg::*;

    typedef struct packed {
        logic [MW-1:0]   n;
        logic [DW+3:0]   rem;
        logic [DW-1:0]   rt;
    } sq_t;

    function automatic sq_t sq_step(input sq_t s);
        sq_t           r;
        logic [DW+3:0] r2;
        logic [DW+3:0] trial;
        r = s;
        r2 = {s.rem[DW+1:0], s.n[MW-1:MW-2]};
        r.n = s.n << 2;
        trial = {2'b00, s.rt, 2'b01};
        if (r2 >= trial)
        begin
            r.rem = r2 - trial;
            r.rt  = {s.rt[DW-2:0], 1'b1};
        end
        else
        begin
            r.rem = r2;
            r.rt  = {s.rt[DW-2:0], 1'b0};
        end
        return r;
    endfunction

    sq_t st_reg [0:IT_STAGES];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0].n   <= rad;
            st_reg[0].rem <= '0;
            st_reg[0].rt  <= '0;
        end
    end

    for (genvar k = 1; k <= IT_STAGES; k++)
    begin : g_stage
        sq_t st_next;
        assign st_next = sq_step(sq_step(st_reg[k-1]));
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[k] <= st_next;
            end
        end
    end

    assign root = MW'(st_reg[IT_STAGES].rt);

endmodule

[rtl/core/complex_arithmetic_unit.sv]
// Complex arithmetic unit top level: handshake, side pipeline and result stage.
//
// Input requests arrive on s_axis: tuser carries the opcode, tdata the two
// complex operands in signed Q8.8. Results leave on m_axis: real and imaginary
// part, the equal flag, the saturation flag and the divide-by-zero flag.
// Every opcode goes through the same pipeline: products, sums, a 9-stage
// divider and square-root section (two recurrence steps per stage), and an
// output register that clips to range. That is 12 register stages;
// throughput is one request per cycle while the receiver does not hold the
// output.
// Reset clears the valid bits only; the pipeline is empty afterwards.
// When the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline holds and s_axis_tready drops with it; bubbles in flight are kept.
// s_axis_tready stays high while the output register is empty or being drained.
module complex_arithmetic_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // a_re, a_im, b_re, b_im
    input  logic [2:0]  s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // res_re, res_im, is_equal, saturated,
                                       // divide_by_zero, zero fill
);
    import cau_pkg::*;

    logic          adv;
    logic [LAT-1:0] vld_reg;
    side_t         side_s2;
    logic [MW-1:0] num_re, num_im, den, q_re, q_im, root;
    side_t         side_reg [0:UNIT_LAT-1];

    assign adv           = ~vld_reg[LAT-1] | m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    cau_front u_front (
        .clk    (clk),
        .adv    (adv),
        .op     (op_t'(s_axis_tuser)),
        .a_re   (word_t'(s_axis_tdata[DW-1:0])),
        .a_im   (word_t'(s_axis_tdata[2*DW-1:DW])),
        .b_re   (word_t'(s_axis_tdata[3*DW-1:2*DW])),
        .b_im   (word_t'(s_axis_tdata[4*DW-1:3*DW])),
        .side   (side_s2),
        .num_re (num_re),
        .num_im (num_im),
        .den    (den)
    );

    cau_div u_div (
        .clk    (clk),
        .adv    (adv),
        .num_re (num_re),
        .num_im (num_im),
        .den    (den),
        .q_re   (q_re),
        .q_im   (q_im)
    );

    cau_sqrt u_sqrt (
        .clk  (clk),
        .adv  (adv),
        .rad  (den),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_s2;
        end
    end

    for (genvar k = 1; k < UNIT_LAT; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    side_t sd;
    sat_t  d_re, d_im, r_mag;
    word_t re_next, im_next;
    logic  sat_next;
    word_t re_reg, im_reg;
    logic  eq_reg, sat_reg, dz_reg;

    always_comb
    begin
        sd    = side_reg[UNIT_LAT-1];
        d_re  = sat_mag(sd.re_neg, q_re);
        d_im  = sat_mag(sd.im_neg, q_im);
        r_mag = sat_mag(1'b0, root);
        unique case (sd.op)
            OP_DIV, OP_INV:
            begin
                if (sd.dz)
                begin
                    re_next  = '0;
                    im_next  = '0;
                    sat_next = 1'b0;
                end
                else
                begin
                    re_next  = d_re.val;
                    im_next  = d_im.val;
                    sat_next = d_re.sat | d_im.sat;
                end
            end
            OP_MAG:
            begin
                re_next  = r_mag.val;
                im_next  = '0;
                sat_next = r_mag.sat;
            end
            default:
            begin
                re_next  = sd.re;
                im_next  = sd.im;
                sat_next = sd.sat;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            re_reg  <= re_next;
            im_reg  <= im_next;
            eq_reg  <= sd.eq;
            sat_reg <= sat_next;
            dz_reg  <= sd.dz;
        end
    end

    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tdata  = {5'b0, dz_reg, sat_reg, eq_reg, im_reg, re_reg};

endmodule

[dv/tb.sv]
// Complex arithmetic unit testbench: directed and random streaming stimulus checked by a predictor.
`timescale 1ns / 100ps

module tb;
    import cau_pkg::*;

    typedef struct {
        op_t         op;
        logic [15:0] ar, ai, br, bi;
    } cplx_req_t;

    typedef struct packed {
        logic [15:0] re, im;
        logic        eq, sat, dz;
    } cplx_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    complex_arithmetic_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    cplx_req_t   pending_reqs[$];
    cplx_res_t   expected_results[$];
    int          errors = 0;
    int          n_results = 0;
    int          n_sat = 0;
    int          n_dz = 0;
    int          cycles = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          long_hold = 0;
    bit          drain_pause = 0;
    bit          stim_done = 0;
    bit          do_stall = 0;

    localparam longint MAXV = 32767;
    localparam longint MINV = -32768;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic longint clip(input bit neg, input longint mag, inout bit sat);
        if (!neg)
        begin
            if (mag > MAXV)
            begin
                sat = 1;
                return MAXV;
            end
            return mag;
        end
        if (mag > -MINV)
        begin
            sat = 1;
            return MINV;
        end
        return -mag;
    endfunction

    function automatic longint frac_quot(input longint mag, input longint den);
        longint q, r;
        q = mag / den;
        r = mag % den;
        if (q >= 32768)
            return 32769;
        for (int i = 0; i < 8; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r -= den;
                q |= 1;
            end
        end
        return q;
    endfunction

    function automatic longint int_sqrt(input longint n);
        longint res, b;
        res = 0;
        b = longint'(1) << 40;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // quotient x / y; returns 0 when y is zero
    function automatic bit cplx_div(input longint xr, xi, yr, yi,
                                    output longint rr, ri, inout bit sat);
        longint den, s;
        den = yr * yr + yi * yi;
        rr = 0;
        ri = 0;
        if (den == 0)
            return 0;
        s = xr * yr + xi * yi;
        rr = clip(s < 0, frac_quot(s < 0 ? -s : s, den), sat);
        s = xi * yr - xr * yi;
        ri = clip(s < 0, frac_quot(s < 0 ? -s : s, den), sat);
        return 1;
    endfunction

    function automatic cplx_res_t predict_result(input cplx_req_t q);
        cplx_res_t r;
        longint ar, ai, br, bi, rr, ri, s;
        bit sat, dz, eq;
        ar = longint'($signed(q.ar));
        ai = longint'($signed(q.ai));
        br = longint'($signed(q.br));
        bi = longint'($signed(q.bi));
        rr = 0;
        ri = 0;
        sat = 0;
        dz = 0;
        eq = 0;
        case (q.op)
            OP_ADD:
            begin
                s = ar + br; rr = clip(s < 0, s < 0 ? -s : s, sat);
                s = ai + bi; ri = clip(s < 0, s < 0 ? -s : s, sat);
            end
            OP_SUB:
            begin
                s = ar - br; rr = clip(s < 0, s < 0 ? -s : s, sat);
                s = ai - bi; ri = clip(s < 0, s < 0 ? -s : s, sat);
            end
            OP_MUL:
            begin
                s = ar * br - ai * bi; rr = clip(s < 0, (s < 0 ? -s : s) >> 8, sat);
                s = ar * bi + ai * br; ri = clip(s < 0, (s < 0 ? -s : s) >> 8, sat);
            end
            OP_DIV: dz = !cplx_div(ar, ai, br, bi, rr, ri, sat);
            OP_CONJ:
            begin
                rr = ar;
                ri = clip(ai > 0, ai < 0 ? -ai : ai, sat);
            end
            OP_INV: dz = !cplx_div(256, 0, ar, ai, rr, ri, sat);
            OP_MAG: rr = clip(0, int_sqrt(ar * ar + ai * ai), sat);
            default: eq = (ar == br) && (ai == bi);
        endcase
        r.re = rr[15:0];
        r.im = ri[15:0];
        r.eq = eq;
        r.sat = sat;
        r.dz = dz;
        return r;
    endfunction

    function automatic logic [15:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3, 4: return 16'($signed($urandom_range(0, 2047)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_req(input op_t op, input logic [15:0] ar, ai, br, bi);
        cplx_req_t q;
        q.op = op;
        q.ar = ar;
        q.ai = ai;
        q.br = br;
        q.bi = bi;
        pending_reqs.push_back(q);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            send_gap <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (send_gap > 0 || drain_pause || pending_reqs.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
            end
            else
            begin
                cplx_req_t q;
                q = pending_reqs.pop_front();
                expected_results.push_back(predict_result(q));
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= q.op;
                s_axis_tdata <= {q.bi, q.br, q.ai, q.ar};
                send_gap <= do_stall ? $urandom_range(0, 9) : 0;
            end
        end
    end

    // receiver readiness and monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                cplx_res_t got, exp_r;
                got.re = m_axis_tdata[15:0];
                got.im = m_axis_tdata[31:16];
                got.eq = m_axis_tdata[32];
                got.sat = m_axis_tdata[33];
                got.dz = m_axis_tdata[34];
                n_results++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    n_sat += exp_r.sat;
                    n_dz += exp_r.dz;
                    if (got != exp_r)
                    begin
                        errors++;
                        $display("%0t: mismatch exp re=%h im=%h eq=%b sat=%b dz=%b",
                                 $time, exp_r.re, exp_r.im, exp_r.eq, exp_r.sat, exp_r.dz);
                        $display("%0t:          got re=%h im=%h eq=%b sat=%b dz=%b",
                                 $time, got.re, got.im, got.eq, got.sat, got.dz);
                    end
                end
            end
            if (long_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                long_hold <= long_hold - 1;
            end
            else if (recv_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else if (m_axis_tready && m_axis_tvalid)
            begin
                if (do_stall && $urandom_range(0, 1))
                begin
                    m_axis_tready <= 1'b0;
                    recv_gap <= $urandom_range(0, 9);
                end
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 200000)
        begin
            $display("timeout");
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners
        for (int o = 0; o < 8; o++)
            queue_req(op_t'(o), 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        for (int o = 0; o < 8; o++)
            queue_req(op_t'(o), 16'h0100, 16'hff00, 16'h0000, 16'h0000);
        queue_req(OP_INV, 16'h0000, 16'h0000, 16'h1234, 16'h0000);
        queue_req(OP_CONJ, 16'h0100, 16'h8000, 16'h0000, 16'h0000);
        queue_req(OP_MAG, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
        queue_req(OP_EQ, 16'h1234, 16'h5678, 16'h1234, 16'h5678);
        queue_req(OP_DIV, 16'h0001, 16'h0000, 16'h0001, 16'h0000);
        queue_req(OP_INV, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        queue_req(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
        wait (pending_reqs.size() == 0 && expected_results.size() == 0);

        // long receiver hold while the sender keeps offering
        do_stall = 1;
        for (int i = 0; i < 40; i++)
            queue_req(op_t'($urandom_range(0, 7)), rand_operand(), rand_operand(),
                      rand_operand(), rand_operand());
        @(posedge clk);
        long_hold <= 60;

        for (int i = 0; i < 400; i++)
        begin
            logic [15:0] ar, ai;
            if (i % 100 == 50)
            begin
                // sender pauses until the pipeline has drained
                wait (pending_reqs.size() == 0);
                drain_pause = 1;
                wait (expected_results.size() == 0);
                drain_pause = 0;
            end
            if (i % 80 == 0)
                do_stall = !do_stall;
            ar = rand_operand();
            ai = rand_operand();
            if ($urandom_range(0, 7) == 0)
                queue_req(OP_EQ, ar, ai, ar, $urandom_range(0, 1) ? ai : rand_operand());
            else
                queue_req(op_t'($urandom_range(0, 7)), ar, ai, rand_operand(), rand_operand());
            if (pending_reqs.size() > 20)
                wait (pending_reqs.size() < 5);
        end
        stim_done = 1;
        wait (pending_reqs.size() == 0 && expected_results.size() == 0);
        repeat (40) @(posedge clk);

        $display("%0d results checked, %0d saturated, %0d divide-by-zero, all opcodes",
                 n_results, n_sat, n_dz);
        $display("with random idling on both sides and a long output hold");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
